// ===== design/drc_pkg.sv =====
// ----------------------------------------------------------------------------
// drc_pkg
// Shared types and constants of the decay rate calculator.
// ----------------------------------------------------------------------------
package drc_pkg;

    // Default number of Taylor terms for exp(-r)
    localparam int DEF_EXP_TERMS = 8;

    // Reset value of the time step register, 1.0 day in Q16.16
    localparam logic [31:0] TS_RESET = 32'h0001_0000;

    // ln(2) and 1.0 in Q0.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    // Reciprocals ceil(2^36 / i), exact floor division of 32-bit values
    localparam logic [63:0] TWO36 = 64'd1 << 36;
    localparam logic [35:0] RECIP_Q36 [16] = '{
        36'd0,                     36'(TWO36),
        36'((TWO36 + 1) / 2),      36'((TWO36 + 2) / 3),
        36'((TWO36 + 3) / 4),      36'((TWO36 + 4) / 5),
        36'((TWO36 + 5) / 6),      36'((TWO36 + 6) / 7),
        36'((TWO36 + 7) / 8),      36'((TWO36 + 8) / 9),
        36'((TWO36 + 9) / 10),     36'((TWO36 + 10) / 11),
        36'((TWO36 + 11) / 12),    36'((TWO36 + 12) / 13),
        36'((TWO36 + 13) / 14),    36'((TWO36 + 14) / 15)
    };

    // Divide by 5: (v * DIV5_RECIP) >> 22, exact for v below 2^20
    localparam logic [19:0] DIV5_RECIP = 20'd838861;

    // Temperature breakpoints in Q8.8 degrees
    localparam logic signed [15:0] T_LO   = 16'sd1280;   // 5
    localparam logic signed [15:0] T_MID1 = 16'sd2560;   // 10
    localparam logic signed [15:0] T_MID2 = 16'sd7680;   // 30
    localparam logic signed [15:0] T_HI   = 16'sd12800;  // 50

    // Decay mode
    typedef enum logic [1:0] {
        MODE_BASIC  = 2'd0,
        MODE_ZERO   = 2'd1,
        MODE_LINEAR = 2'd2,
        MODE_DENIT  = 2'd3
    } t_mode;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_MODE = 1'b0,
        REG_STEP = 1'b1
    } t_reg;

    // Temperature factor class
    typedef enum logic [1:0] {
        TF_ZERO = 2'd0,
        TF_ONE  = 2'd1,
        TF_RAMP = 2'd2
    } t_tfclass;

endpackage

// ===== design/drc_delay.sv =====
// ----------------------------------------------------------------------------
// drc_delay
// Fixed-length register line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module drc_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [D];

    // shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < D; k++) r_line[k] <= '0;
        end else begin
            r_line[0] <= i_d;
            for (int k = 1; k < D; k++) r_line[k] <= r_line[k-1];
        end
    end

    assign o_q = r_line[D-1];

endmodule

// ===== design/drc_div.sv =====
// ----------------------------------------------------------------------------
// drc_div
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// ----------------------------------------------------------------------------
module drc_div #(
    parameter int QW = 48
) (
    input  logic          i_clk,
    input  logic [31:0]   i_rem0,   // initial remainder, below i_den
    input  logic [QW-1:0] i_num,    // dividend bits shifted in, MSB first
    input  logic [31:0]   i_den,
    output logic [QW-1:0] o_quo
);

    logic [31:0]   r_rem  [QW];
    logic [QW-1:0] r_bits [QW];   // remaining dividend bits over quotient bits
    logic [31:0]   r_den  [QW];

    logic [31:0]   s_rem   [QW];
    logic [QW-1:0] s_bits  [QW];
    logic [31:0]   s_den   [QW];
    logic [32:0]   s_trial [QW];
    logic          s_ge    [QW];

    // per-stage trial subtract
    always_comb begin
        s_rem[0]  = i_rem0;
        s_bits[0] = i_num;
        s_den[0]  = i_den;
        for (int k = 1; k < QW; k++) begin
            s_rem[k]  = r_rem[k-1];
            s_bits[k] = r_bits[k-1];
            s_den[k]  = r_den[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            s_trial[k] = {s_rem[k], s_bits[k][QW-1]};
            s_ge[k]    = (s_trial[k] >= {1'b0, s_den[k]});
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QW; k++) begin
            r_rem[k]  <= s_ge[k] ? 32'(s_trial[k] - {1'b0, s_den[k]}) : s_trial[k][31:0];
            r_bits[k] <= {s_bits[k][QW-2:0], s_ge[k]};
            r_den[k]  <= s_den[k];
        end
    end

    assign o_quo = r_bits[QW-1];

endmodule

// ===== design/drc_exp.sv =====
// ----------------------------------------------------------------------------
// drc_exp
// Pipelined exp(-k*dt) in Q0.32: range reduction by ln2, Taylor series,
// clamp and shift.
// ----------------------------------------------------------------------------
module drc_exp #(
    parameter int EXP_TERMS = drc_pkg::DEF_EXP_TERMS
) (
    input  logic        i_clk,
    input  logic [31:0] i_k,      // Q8.24
    input  logic [31:0] i_dt,     // Q16.16
    output logic [32:0] o_e       // Q0.32
);
    import drc_pkg::*;

    localparam int NT = EXP_TERMS - 2;

    // floor(2^42 / ln2_q32), scales the top 11 bits of x32 to an estimate of n
    localparam logic [10:0] LN2_RECIP = 11'd1477;

    typedef struct packed {
        logic [31:0]        r;
        logic signed [35:0] sum;
        logic [5:0]         n;
        logic               big;
    } t_exp_side;

    // product and range check
    logic [63:0] r_x;
    logic        r_big;
    logic [36:0] r_x32;

    always_ff @(posedge i_clk) begin
        r_x   <= 64'(i_k) * 64'(i_dt);
        r_big <= (r_x >= (64'd32 << 40));
        r_x32 <= r_x[44:8];
    end

    // n estimate from the top bits, never above floor(x32 / ln2) and at most one below
    logic [21:0] s_nprod;
    logic [5:0]  r_nest;
    logic [36:0] r_xa;
    logic        r_biga;

    assign s_nprod = 22'(r_x32[36:26]) * 22'(LN2_RECIP);

    always_ff @(posedge i_clk) begin
        r_nest <= s_nprod[21:16];
        r_xa   <= r_x32;
        r_biga <= r_big;
    end

    // remainder for the estimate, below 2*ln2
    logic [37:0] s_nlp;
    logic [36:0] s_r0;
    logic [32:0] r_r0;
    logic [5:0]  r_nb;
    logic        r_bigb;

    assign s_nlp = 38'(r_nest) * 38'(LN2_Q32);
    assign s_r0  = r_xa - s_nlp[36:0];

    always_ff @(posedge i_clk) begin
        r_r0   <= s_r0[32:0];
        r_nb   <= r_nest;
        r_bigb <= r_biga;
    end

    // one correction step: r in [0, ln2)
    logic        s_rge;
    logic [31:0] r_rc;
    logic [5:0]  r_nc;
    logic        r_bigc;

    assign s_rge = (r_r0 >= 33'(LN2_Q32));

    always_ff @(posedge i_clk) begin
        r_rc   <= s_rge ? 32'(r_r0 - 33'(LN2_Q32)) : r_r0[31:0];
        r_nc   <= r_nb + 6'(s_rge);
        r_bigc <= r_bigb;
    end

    // first term: term1 = r, sum = 1 - r
    logic [31:0] r_i_term;
    t_exp_side   r_i_side;

    always_ff @(posedge i_clk) begin
        r_i_term       <= r_rc;
        r_i_side.r     <= r_rc;
        r_i_side.sum   <= $signed(36'(ONE_Q32) - 36'(r_rc));
        r_i_side.n     <= r_nc;
        r_i_side.big   <= r_bigc;
    end

    // Taylor terms i = 2 .. EXP_TERMS-1, two stages each
    logic [31:0] r_a_prod [NT];
    t_exp_side   r_a_side [NT];
    logic [31:0] r_b_term [NT];
    t_exp_side   r_b_side [NT];

    logic [31:0] s_src_term [NT];
    t_exp_side   s_src_side [NT];
    logic [63:0] s_tr       [NT];
    logic [67:0] s_mq       [NT];
    logic [31:0] s_q        [NT];
    t_exp_side   s_b_side   [NT];

    always_comb begin
        for (int t = 0; t < NT; t++) begin
            if (t == 0) begin
                s_src_term[t] = r_i_term;
                s_src_side[t] = r_i_side;
            end else begin
                s_src_term[t] = r_b_term[t-1];
                s_src_side[t] = r_b_side[t-1];
            end
            s_tr[t] = 64'(s_src_term[t]) * 64'(s_src_side[t].r);
            s_mq[t] = 68'(r_a_prod[t]) * 68'(RECIP_Q36[t+2]);
            s_q[t]  = s_mq[t][67:36];
            s_b_side[t] = r_a_side[t];
            // even index adds, odd subtracts
            if ((t % 2) == 0) begin
                s_b_side[t].sum = r_a_side[t].sum + $signed({4'b0, s_q[t]});
            end else begin
                s_b_side[t].sum = r_a_side[t].sum - $signed({4'b0, s_q[t]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < NT; t++) begin
            r_a_prod[t] <= s_tr[t][63:32];
            r_a_side[t] <= s_src_side[t];
            r_b_term[t] <= s_q[t];
            r_b_side[t] <= s_b_side[t];
        end
    end

    // clamp to [0,1] and scale by 2^-n, zero for a large argument
    t_exp_side   s_last;
    logic [32:0] s_clamp;
    logic [32:0] r_e;

    always_comb begin
        s_last = r_b_side[NT-1];
        if (s_last.sum[35]) begin
            s_clamp = '0;
        end else if (s_last.sum > $signed(36'(ONE_Q32))) begin
            s_clamp = ONE_Q32;
        end else begin
            s_clamp = s_last.sum[32:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_e <= s_last.big ? 33'd0 : (s_clamp >> s_last.n);
    end

    assign o_e = r_e;

endmodule

// ===== design/decay_rate_calculator.sv =====
// ----------------------------------------------------------------------------
// decay_rate_calculator
// Per-compartment mass loss rate of a decaying constituent, fully pipelined.
// ----------------------------------------------------------------------------
// One compartment is taken on every cycle in which start is high; busy stays
// low. done pulses for one cycle for each compartment, carrying rate and
// rate_valid; results come out in order and must be taken when shown. The
// latency is set by the bit-per-stage dividers (16-bit storage ratio, 49-bit
// rate over time step) and the two-stage-per-term Taylor chain of the exp
// unit. decay_mode and time_step must only be written while no compartment
// is in flight.
module decay_rate_calculator #(
    parameter int EXP_TERMS = drc_pkg::DEF_EXP_TERMS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command
    input  logic        start,
    output logic        busy,
    input  logic        i_apply,
    input  logic        i_coeff_given,
    input  logic [31:0] i_coefficient,
    input  logic [31:0] i_mass,
    input  logic signed [15:0] i_temperature,
    input  logic [31:0] i_water_storage,
    input  logic [31:0] i_storage_max,
    // result
    output logic        o_done,
    output logic [31:0] o_rate,
    output logic        o_rate_valid,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import drc_pkg::*;

    // stage timing, counted in registers from the input stage
    localparam int T_FS     = 16;
    localparam int T_C1     = 2;
    localparam int T_K      = 18;
    localparam int LAT_EXP  = 2 * EXP_TERMS + 3;
    localparam int T_E      = T_K + LAT_EXP;
    localparam int LIN_QW   = 49;
    localparam int CAP_QW   = 48;
    localparam int T_Q      = T_E + 1 + LIN_QW;
    localparam int LAT_ITEM = T_Q + 2;

    // configuration registers
    t_mode       r_mode;
    logic [31:0] r_time_step;
    logic [31:0] dt_eff;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_BASIC;
            r_time_step <= TS_RESET;
        end else if (cfg_wr) begin
            case (t_reg'(paddr[2]))
                REG_MODE: r_mode      <= t_mode'(pwdata[1:0]);
                REG_STEP: r_time_step <= pwdata;
                default:  r_mode      <= r_mode;
            endcase
        end
    end

    always_comb begin
        case (t_reg'(paddr[2]))
            REG_MODE: prdata = {30'b0, r_mode};
            REG_STEP: prdata = r_time_step;
            default:  prdata = '0;
        endcase
    end

    // zero time step counts as one LSB
    assign dt_eff = (r_time_step == '0) ? 32'd1 : r_time_step;

    // input stage
    logic        accept;
    logic        r_v0, r_rv0;
    logic [31:0] r_coeff0, r_mass0, r_stor0, r_smax0;
    logic signed [15:0] r_temp0;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rv0    <= i_apply && i_coeff_given;
            r_coeff0 <= i_coefficient;
            r_mass0  <= i_mass;
            r_temp0  <= i_temperature;
            r_stor0  <= i_water_storage;
            r_smax0  <= i_storage_max;
        end
    end

    // storage factor: storage * 2^16 / max
    logic [15:0] fs_quo;
    logic        ge16;

    drc_div #(.QW(T_FS)) u_fs_div (
        .i_clk  (i_clk),
        .i_rem0 (r_stor0),
        .i_num  ('0),
        .i_den  (r_smax0),
        .o_quo  (fs_quo)
    );

    drc_delay #(.W(1), .D(T_FS)) u_ge_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r_stor0 >= r_smax0),
        .o_q     (ge16)
    );

    // temperature factor, two stages
    t_tfclass    s_tcls, r_tcls1;
    logic [15:0] s_lo_d, s_hi_d;
    logic [19:0] s_tv;
    logic [39:0] r_tprod1;
    logic [16:0] r_c1_2, c1_16;

    always_comb begin
        s_lo_d = 16'(r_temp0 - T_LO);
        s_hi_d = 16'(T_HI - r_temp0);
        if (r_temp0 <= T_LO || r_temp0 >= T_HI) begin
            s_tcls = TF_ZERO;
        end else if (r_temp0 >= T_MID1 && r_temp0 <= T_MID2) begin
            s_tcls = TF_ONE;
        end else begin
            s_tcls = TF_RAMP;
        end
        // lower ramp (T-5)/5, upper ramp (50-T)/20
        if (r_temp0 < T_MID1) begin
            s_tv = {1'b0, s_lo_d[10:0], 8'b0};
        end else begin
            s_tv = {1'b0, s_hi_d[12:0], 6'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tcls1  <= s_tcls;
        r_tprod1 <= 40'(s_tv) * 40'(DIV5_RECIP);
        case (r_tcls1)
            TF_ZERO: r_c1_2 <= '0;
            TF_ONE:  r_c1_2 <= 17'h1_0000;
            TF_RAMP: r_c1_2 <= r_tprod1[38:22];
            default: r_c1_2 <= '0;
        endcase
    end

    drc_delay #(.W(17), .D(T_FS - T_C1)) u_c1_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r_c1_2),
        .o_q     (c1_16)
    );

    logic [31:0] coeff16;

    drc_delay #(.W(32), .D(T_FS)) u_coeff_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r_coeff0),
        .o_q     (coeff16)
    );

    // effective coefficient
    logic [48:0] s_m1p, s_kp;
    logic [31:0] r_m1, r_coeff17, r_k;
    logic [16:0] r_fs17;

    assign s_m1p = 49'(coeff16) * 49'(c1_16);
    assign s_kp  = 49'(r_m1) * 49'(r_fs17);

    always_ff @(posedge i_clk) begin
        r_m1      <= s_m1p[47:16];
        r_fs17    <= ge16 ? 17'h1_0000 : {1'b0, fs_quo};
        r_coeff17 <= coeff16;
        r_k       <= (r_mode == MODE_LINEAR) ? r_coeff17 : s_kp[47:16];
    end

    // exp(-k*dt)
    logic [32:0] e_te;

    drc_exp #(.EXP_TERMS(EXP_TERMS)) u_exp (
        .i_clk (i_clk),
        .i_k   (r_k),
        .i_dt  (dt_eff),
        .o_e   (e_te)
    );

    logic [31:0] mass_te;

    drc_delay #(.W(32), .D(T_E)) u_mass_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r_mass0),
        .o_q     (mass_te)
    );

    // mass * (1 - e) >> 16, then divide by time step
    logic [64:0] s_pp;
    logic [48:0] r_p;
    logic [48:0] lin_q;

    assign s_pp = 65'(mass_te) * 65'(ONE_Q32 - e_te);

    always_ff @(posedge i_clk) begin
        r_p <= s_pp[64:16];
    end

    drc_div #(.QW(LIN_QW)) u_lin_div (
        .i_clk  (i_clk),
        .i_rem0 ('0),
        .i_num  (r_p),
        .i_den  (dt_eff),
        .o_quo  (lin_q)
    );

    // cap = mass * 2^16 / time step
    logic [47:0] cap48, cap_q;

    drc_div #(.QW(CAP_QW)) u_cap_div (
        .i_clk  (i_clk),
        .i_rem0 ('0),
        .i_num  ({r_mass0, 16'b0}),
        .i_den  (dt_eff),
        .o_quo  (cap48)
    );

    drc_delay #(.W(48), .D(T_Q - CAP_QW)) u_cap_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (cap48),
        .o_q     (cap_q)
    );

    // basic and zero-order rates
    logic [63:0] s_bp;
    logic [39:0] r_alt1, alt_q;

    assign s_bp = 64'(r_coeff0) * 64'(r_mass0);

    always_ff @(posedge i_clk) begin
        r_alt1 <= (r_mode == MODE_BASIC) ? s_bp[63:24] : 40'(r_coeff0[31:8]);
    end

    drc_delay #(.W(40), .D(T_Q - 1)) u_alt_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r_alt1),
        .o_q     (alt_q)
    );

    logic [1:0] vq;

    drc_delay #(.W(2), .D(T_Q)) u_vld_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     ({r_v0, r_rv0 && r_v0}),
        .o_q     (vq)
    );

    // select, cap, saturate
    logic [48:0] s_sel, s_capped;
    logic [31:0] s_sat;
    logic        r_done, r_rate_valid;
    logic [31:0] r_rate;

    always_comb begin
        if (r_mode == MODE_BASIC || r_mode == MODE_ZERO) begin
            s_sel = 49'(alt_q);
        end else begin
            s_sel = lin_q;
        end
        s_capped = (s_sel > 49'(cap_q)) ? 49'(cap_q) : s_sel;
        s_sat    = (s_capped[48:32] != '0) ? 32'hFFFF_FFFF : s_capped[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done       <= 1'b0;
            r_rate_valid <= 1'b0;
        end else begin
            r_done       <= vq[1];
            r_rate_valid <= vq[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rate <= vq[0] ? s_sat : 32'd0;
    end

    assign o_done       = r_done;
    assign o_rate       = r_rate;
    assign o_rate_valid = r_rate_valid;

`ifndef NO_ASSERTIONS
    // every accepted transaction yields its result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT_ITEM o_done)
        else $error("result missing after pipeline latency");

    // a valid rate only comes with the strobe
    a_valid_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rate_valid |-> o_done)
        else $error("rate_valid without done");

    // skipped compartments report zero
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rate_valid) |-> (o_rate == 32'd0))
        else $error("nonzero rate on skipped compartment");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the decay rate calculator. Drives compartments through the
// command port, predicts each loss rate in fixed point, and compares every
// result against the oldest pending prediction. Configuration goes through
// the APB port only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import drc_pkg::*;

    localparam int    EXP_N     = 8;
    localparam int    LATENCY   = 2 * EXP_N + 73;
    localparam int    LIMIT     = 400000;
    localparam [63:0] LN2       = 64'd2977044472;
    localparam [63:0] ONE       = 64'h1_0000_0000;

    typedef struct packed {
        logic        apply;
        logic        given;
        logic [31:0] coeff;
        logic [31:0] mass;
        logic signed [15:0] temp;
        logic [31:0] stor;
        logic [31:0] smax;
    } t_comp;

    typedef struct packed {
        logic [31:0] rate;
        logic        valid;
    } t_rate;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic        i_apply = 0, i_coeff_given = 0;
    logic [31:0] i_coefficient = 0, i_mass = 0, i_water_storage = 0, i_storage_max = 0;
    logic signed [15:0] i_temperature = 0;
    logic        o_done;
    logic [31:0] o_rate;
    logic        o_rate_valid;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    decay_rate_calculator #(.EXP_TERMS(EXP_N)) dut (.*);

    // predictor copy of the registers
    t_mode       cur_mode = MODE_BASIC;
    logic [31:0] cur_step = TS_RESET;

    t_rate       pending_rates[$];
    int          n_errors = 0;
    int          n_rates = 0;
    int          n_sent = 0;
    int          cycles = 0;
    int          send_gap_pct = 0;
    bit          saw_mode[4];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // exp(-x), x in Q24.40, result in Q0.32
    function automatic logic [63:0] exp_neg(logic [63:0] x);
        logic [63:0] x32, n, r, term;
        longint      sum;
        if (x >= (64'd32 << 40)) return 0;
        x32  = x >> 8;
        n    = x32 / LN2;
        r    = x32 - n * LN2;
        term = ONE;
        sum  = longint'(term);
        for (int i = 1; i < EXP_N; i++) begin
            term = ((term * r) >> 32) / i;
            if (i & 1) sum -= longint'(term);
            else       sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > longint'(ONE)) sum = longint'(ONE);
        if (n >= 63) return 0;
        return 64'(sum) >> n;
    endfunction

    function automatic logic [63:0] linear_loss(logic [63:0] k, logic [63:0] m,
                                                logic [63:0] dt);
        logic [63:0] e;
        e = exp_neg(k * dt);
        return ((m * (ONE - e)) >> 16) / dt;
    endfunction

    function automatic logic [63:0] temp_scale(logic signed [15:0] t);
        if (t <= T_LO || t >= T_HI) return 0;
        if (t >= T_MID1 && t <= T_MID2) return 65536;
        if (t < T_MID1) return (64'(32'(t - T_LO)) * 256) / 5;
        return (64'(32'(T_HI - t)) * 64) / 5;
    endfunction

    function automatic t_rate predict_rate(t_comp c);
        t_rate       res;
        logic [63:0] dt, cap, rate, fs, k;
        res = '0;
        if (!c.apply || !c.given) return res;
        dt  = (cur_step == 0) ? 64'd1 : 64'(cur_step);
        cap = (64'(c.mass) << 16) / dt;
        case (cur_mode)
            MODE_BASIC:  rate = (64'(c.coeff) * c.mass) >> 24;
            MODE_ZERO:   rate = 64'(c.coeff) >> 8;
            MODE_LINEAR: rate = linear_loss(c.coeff, c.mass, dt);
            default: begin
                fs   = (c.stor >= c.smax) ? 64'd65536 : (64'(c.stor) << 16) / c.smax;
                k    = ((64'(c.coeff) * temp_scale(c.temp)) >> 16) * fs >> 16;
                rate = linear_loss(k, c.mass, dt);
            end
        endcase
        if (rate > cap) rate = cap;
        if (rate > 64'hFFFF_FFFF) rate = 64'hFFFF_FFFF;
        res.rate  = rate[31:0];
        res.valid = 1'b1;
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_rate want;
        if (i_rst_n && o_done) begin
            if (pending_rates.size() == 0) begin
                $display("%0t: unexpected result rate=%h valid=%b", $time, o_rate,
                         o_rate_valid);
                n_errors++;
            end else begin
                want = pending_rates.pop_front();
                n_rates++;
                if (o_rate !== want.rate) begin
                    $display("%0t: rate expected %h actual %h", $time, want.rate, o_rate);
                    n_errors++;
                end
                if (o_rate_valid !== want.valid) begin
                    $display("%0t: rate_valid expected %b actual %b", $time, want.valid,
                             o_rate_valid);
                    n_errors++;
                end
            end
        end
    end

    // one transaction on the command port, with optional random gap;
    // start stays high so that a following transaction can go back to back
    task automatic send_comp(t_comp c);
        while ($urandom_range(99) < send_gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start         <= 1'b1;
        i_apply       <= c.apply;
        i_coeff_given <= c.given;
        i_coefficient <= c.coeff;
        i_mass        <= c.mass;
        i_temperature <= c.temp;
        i_water_storage <= c.stor;
        i_storage_max <= c.smax;
        do @(posedge i_clk); while (busy);
        pending_rates.push_back(predict_rate(c));
        saw_mode[cur_mode] = 1;
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_rates.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic reg_write(t_reg idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MODE) cur_mode = t_mode'(val[1:0]);
        else                 cur_step = val;
        @(negedge i_clk);
    endtask

    task automatic configure(t_mode m, logic [31:0] step);
        drain();
        reg_write(REG_MODE, {30'd0, m});
        reg_write(REG_STEP, step);
    endtask

    function automatic logic [31:0] rand_wide();
        case ($urandom_range(4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(32'h0010_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_comp rand_comp();
        t_comp c;
        c.apply = ($urandom_range(9) != 0);
        c.given = ($urandom_range(9) != 0);
        c.coeff = ($urandom_range(1)) ? $urandom_range(32'h0400_0000) : rand_wide();
        c.mass  = rand_wide();
        case ($urandom_range(2))
            0: c.temp = 16'($urandom);
            default: c.temp = 16'($urandom_range(14000));
        endcase
        c.stor = rand_wide();
        c.smax = ($urandom_range(3) == 0) ? rand_wide() : $urandom_range(1, 32'h0100_0000);
        return c;
    endfunction

    function automatic t_comp mk(logic a, logic g, logic [31:0] k, logic [31:0] m,
                                 logic signed [15:0] t, logic [31:0] s, logic [31:0] x);
        return '{a, g, k, m, t, s, x};
    endfunction

    // skipped and missing coefficient, field extremes under every mode, temperature breakpoints and time step extremes
    task automatic test_directed();
        logic signed [15:0] temps[8] = '{16'sh8000, 16'sd1280, 16'sd1281, 16'sd2560,
                                         16'sd7680, 16'sd9000, 16'sd12800, 16'sh7FFF};
        send_comp(mk(0, 1, 32'h0100_0000, 32'h0001_0000, 0, 0, 1));
        send_comp(mk(1, 0, 32'h0100_0000, 32'h0001_0000, 0, 0, 1));
        for (int m = 0; m < 4; m++) begin
            configure(t_mode'(m), TS_RESET);
            send_comp(mk(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sh7FFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF));
            send_comp(mk(1, 1, 32'h0000_0001, 32'h0000_0001, 16'sh8000, 0, 0));
            send_comp(mk(1, 1, 32'h0080_0000, 32'h0010_0000, 16'sd5000, 32'h10,
                         32'h20));
        end
        for (int i = 0; i < 8; i++)
            send_comp(mk(1, 1, 32'h0100_0000, 32'h0064_0000, temps[i], 5, 5));
        // zero time step counts as one LSB
        configure(MODE_LINEAR, 32'd0);
        send_comp(mk(1, 1, 32'h0100_0000, 32'h0064_0000, 0, 0, 1));
        configure(MODE_BASIC, 32'hFFFF_FFFF);
        send_comp(mk(1, 1, 32'h0100_0000, 32'hFFFF_FFFF, 0, 0, 1));
    endtask

    task automatic test_random_phase(int count, int gap_pct);
        t_mode       m;
        logic [31:0] step;
        send_gap_pct = gap_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                m = t_mode'($urandom_range(3));
                case ($urandom_range(3))
                    0: step = 32'd1;
                    1: step = 32'hFFFF_FFFF;
                    2: step = $urandom_range(32'h0000_4000, 32'h0010_0000);
                    default: step = $urandom;
                endcase
                configure(m, step);
            end
            send_comp(rand_comp());
        end
    endtask

    // sender waits for an empty pipeline mid-stream
    task automatic test_pause();
        send_gap_pct = 0;
        for (int i = 0; i < 20; i++) send_comp(rand_comp());
        start <= 1'b0;
        while (pending_rates.size() != 0) @(negedge i_clk);
        for (int i = 0; i < 20; i++) send_comp(rand_comp());
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_phase(400, 9);
        test_random_phase(400, 73);
        test_pause();
        test_random_phase(360, 0);
        drain();
        $display("Covered %0d transactions, %0d rates checked; modes seen %b%b%b%b",
                 n_sent, n_rates, saw_mode[3], saw_mode[2], saw_mode[1], saw_mode[0]);
        $display("Time steps from zero to full scale; skipped and extreme fields.");
        if (n_errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
